// ===== sv/tsrq_pkg.sv =====
// Package: shared types and constants for the thread run queue scheduler.
`timescale 1ns / 1ps
package tsrq_pkg;
	localparam int THREAD_COUNT = 64;
	localparam int SUSPEND_BITS = 16;
	localparam int TW = $clog2(THREAD_COUNT);
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0, CMD_SUSPEND = 3'd1, CMD_RESUME = 3'd2, CMD_ABORT = 3'd3,
		CMD_DESTROY = 3'd4, CMD_YIELD = 3'd5, CMD_SCHEDULE = 3'd6, CMD_BAD = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_STOPPED = 2'd0, ST_RUNNABLE = 2'd1, ST_RUNNING = 2'd2, ST_REMOVED = 2'd3
	} tstate_t;

	typedef enum logic [1:0] {
		SC_OK = 2'd0, SC_INVALID = 2'd1, SC_OVERFLOW = 2'd2, SC_COUNT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_READ, BK_EXEC, BK_LINK, BK_SCHED, BK_SREAD, BK_SEXEC, BK_OUT
	} bstate_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [TW-1:0]   tid;
		logic            bad;
	} op_t;

	typedef struct packed {
		logic [1:0]    status_code;
		logic [5:0]    next_thread;
		logic          next_is_idle;
		logic          switched;
		logic          kick_cpu;
		logic          interrupt_running;
		logic          dead_valid;
		logic [5:0]    dead_thread;
	} res_t;
endpackage

// ===== sv/tsrq_front.sv =====
// Front end: accepts command beats, classifies them and queues them for execution.
`timescale 1ns / 1ps
module tsrq_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            stall,
	input  logic [2:0]      command,
	input  logic [5:0]      thread_id,
	output logic            op_valid,
	input  logic            op_take,
	output tsrq_pkg::op_t   op
);
	import tsrq_pkg::*;

	op_t  buf_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	op_t  in_op;

	assign stall = (cnt_q == 2'(QDEPTH));
	assign op_valid = (cnt_q != 2'd0);
	assign op = buf_q[rp_q];

	always_comb begin
		in_op.cmd = cmd_t'(command);
		in_op.tid = thread_id[TW-1:0];
		in_op.bad = (command == CMD_BAD) ||
			((command != CMD_SCHEDULE) && ({26'd0, thread_id} >= THREAD_COUNT));
	end

	always_ff @(posedge clk) begin
		if (valid && !stall) buf_q[wp_q] <= in_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (valid && !stall) wp_q <= ~wp_q;
			if (op_valid && op_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(valid && !stall) - 2'(op_valid && op_take);
		end
	end
endmodule

// ===== sv/tsrq_back.sv =====
// Back end: thread table, linked run queue and command execution sequencer.
`timescale 1ns / 1ps
module tsrq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_take,
	input  tsrq_pkg::op_t   op,
	output logic            res_valid,
	input  logic            res_stall,
	output tsrq_pkg::res_t  res
);
	import tsrq_pkg::*;

	localparam logic [SUSPEND_BITS-1:0] CMAX = '1;

	tstate_t                 ts_mem  [THREAD_COUNT];
	logic [SUSPEND_BITS-1:0] cnt_mem [THREAD_COUNT];
	logic [THREAD_COUNT-1:0] vld_q;
	logic [THREAD_COUNT-1:0] ps_q, pd_q, py_q;
	logic [TW-1:0] nxt_mem [THREAD_COUNT];
	logic [TW-1:0] prv_mem [THREAD_COUNT];
	logic [TW-1:0] head_q, tail_q, run_q;
	logic          qe_q, idle_q;

	bstate_t st_q, st_d;
	op_t     op_q;
	res_t    res_q;
	logic [TW-1:0] nx_q, pv_q, cur_q;
	logic          cur_idle_q;

	logic          nxt_we, prv_we;
	logic [TW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, rd_a;

	tstate_t                 ts_rd_q;
	logic [SUSPEND_BITS-1:0] cnt_rd_q;
	logic                    vld_rd_q;
	logic [TW-1:0]           ta;
	logic                    ts_we, cnt_we;
	logic [TW-1:0]           ts_wa, cnt_wa;
	tstate_t                 ts_wd;
	logic [SUSPEND_BITS-1:0] cnt_wd;

	logic [TW-1:0] t;
	tstate_t       tst;
	logic [SUSPEND_BITS-1:0] tc;
	assign t   = op_q.tid;
	assign tst = vld_rd_q ? ts_rd_q : ST_REMOVED;
	assign tc  = vld_rd_q ? cnt_rd_q : '0;
	assign ta  = (st_q == BK_IDLE) ? run_q : t;

	assign op_take = (st_q == BK_IDLE);
	assign res_valid = (st_q == BK_OUT);
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (ts_we) ts_mem[ts_wa] <= ts_wd;
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		ts_rd_q <= ts_mem[ta];
		cnt_rd_q <= cnt_mem[ta];
		vld_rd_q <= vld_q[ta];
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		nx_q <= nxt_mem[rd_a];
		pv_q <= prv_mem[rd_a];
	end

	always_comb begin
		st_d = st_q;
		rd_a = (st_q == BK_SREAD) ? head_q : t;
		case (st_q)
			BK_IDLE:  if (op_valid) st_d = (op.cmd == CMD_SCHEDULE && !op.bad) ? BK_SCHED : BK_READ;
			BK_READ:  st_d = BK_EXEC;
			BK_EXEC:  st_d = BK_LINK;
			BK_LINK:  st_d = BK_OUT;
			BK_SCHED: st_d = BK_SREAD;
			BK_SREAD: st_d = BK_SEXEC;
			BK_SEXEC: st_d = BK_OUT;
			BK_OUT:   if (!res_stall) st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		ts_we = 1'b0; ts_wa = t; ts_wd = ST_REMOVED;
		cnt_we = 1'b0; cnt_wa = t; cnt_wd = tc;
		case (st_q)
			BK_EXEC:
				if (!op_q.bad) begin
					case (op_q.cmd)
						CMD_ADD:
							if (tst == ST_REMOVED) begin
								ts_we = 1'b1; ts_wd = ST_STOPPED;
								cnt_we = 1'b1; cnt_wd = SUSPEND_BITS'(1);
							end
						CMD_SUSPEND:
							if (tst == ST_RUNNABLE) begin
								ts_we = 1'b1; ts_wd = ST_STOPPED;
								cnt_we = 1'b1; cnt_wd = SUSPEND_BITS'(1);
							end else if (tst == ST_STOPPED && tc != '0 && tc != CMAX) begin
								cnt_we = 1'b1; cnt_wd = tc + 1'b1;
							end
						CMD_RESUME, CMD_ABORT:
							if (tst == ST_STOPPED && tc != '0) begin
								cnt_we = 1'b1; cnt_wd = tc - 1'b1;
								if (tc == SUSPEND_BITS'(1)) begin
									ts_we = 1'b1; ts_wd = ST_RUNNABLE;
								end
							end
						CMD_DESTROY:
							if (tst == ST_RUNNABLE || tst == ST_STOPPED) begin
								ts_we = 1'b1; ts_wd = ST_REMOVED;
							end
						default: ;
					endcase
				end
			BK_SCHED:
				if (!cur_idle_q) begin
					ts_wa = cur_q; cnt_wa = cur_q;
					if (pd_q[cur_q]) begin
						ts_we = 1'b1; ts_wd = ST_REMOVED;
					end else if (ps_q[cur_q]) begin
						ts_we = 1'b1; ts_wd = ST_STOPPED;
						if (tc != CMAX) begin
							cnt_we = 1'b1; cnt_wd = tc + 1'b1;
						end
					end else if (py_q[cur_q]) begin
						ts_we = 1'b1; ts_wd = ST_RUNNABLE;
					end
				end
			BK_SEXEC:
				if (!do_rm_q && !qe_q) begin
					ts_we = 1'b1; ts_wa = head_q; ts_wd = ST_RUNNING;
				end
			default: ;
		endcase
	end

	// Queue link updates happen in one place per cycle; removal takes EXEC then LINK.
	logic do_rm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			vld_q <= '0;
			ps_q <= '0; pd_q <= '0; py_q <= '0;
			head_q <= '0; tail_q <= '0; qe_q <= 1'b1;
			run_q <= '0; idle_q <= 1'b1;
			do_rm_q <= 1'b0;
			op_q <= '0;
			res_q <= '0;
			cur_q <= '0;
			cur_idle_q <= 1'b1;
		end else begin
			st_q <= st_d;
			case (st_q)
				BK_IDLE: begin
					if (op_valid) op_q <= op;
					res_q <= '0;
					do_rm_q <= 1'b0;
					cur_q <= run_q;
					cur_idle_q <= idle_q;
				end
				BK_EXEC: begin
					if (op_q.bad) res_q.status_code <= SC_INVALID;
					else case (op_q.cmd)
						CMD_ADD:
							if (tst != ST_REMOVED) res_q.status_code <= SC_INVALID;
							else begin
								vld_q[t] <= 1'b1;
								ps_q[t] <= 1'b0; pd_q[t] <= 1'b0; py_q[t] <= 1'b0;
							end
						CMD_SUSPEND:
							case (tst)
								ST_RUNNING: ps_q[t] <= 1'b1;
								ST_RUNNABLE: do_rm_q <= 1'b1;
								ST_STOPPED:
									if (tc == '0) res_q.status_code <= SC_COUNT;
									else if (tc == CMAX) res_q.status_code <= SC_OVERFLOW;
								default: ;
							endcase
						CMD_RESUME, CMD_ABORT:
							case (tst)
								ST_RUNNING:
									if (op_q.cmd == CMD_RESUME) begin
										if (!ps_q[t]) res_q.status_code <= SC_COUNT;
										ps_q[t] <= 1'b0;
									end
								ST_RUNNABLE:
									if (op_q.cmd == CMD_RESUME) res_q.status_code <= SC_COUNT;
								ST_STOPPED:
									if (tc == '0) res_q.status_code <= SC_COUNT;
									else if (tc == SUSPEND_BITS'(1)) begin
										res_q.kick_cpu <= 1'b1;
										if (qe_q) begin head_q <= t; qe_q <= 1'b0; end
										tail_q <= t;
									end
								default: ;
							endcase
						CMD_DESTROY:
							case (tst)
								ST_RUNNING: begin pd_q[t] <= 1'b1; res_q.interrupt_running <= 1'b1; end
								ST_RUNNABLE, ST_STOPPED: begin
									do_rm_q <= (tst == ST_RUNNABLE);
									res_q.dead_valid <= 1'b1;
									res_q.dead_thread <= 6'(t);
								end
								default: res_q.status_code <= SC_INVALID;
							endcase
						CMD_YIELD:
							if (tst == ST_RUNNING) py_q[t] <= 1'b1;
							else res_q.status_code <= SC_INVALID;
						default: res_q.status_code <= SC_INVALID;
					endcase
				end
				BK_LINK:
					if (do_rm_q && !qe_q) begin
						if (head_q == t && tail_q == t) qe_q <= 1'b1;
						else begin
							if (head_q == t) head_q <= nx_q;
							if (tail_q == t) tail_q <= pv_q;
						end
					end
				BK_SCHED:
					if (!cur_idle_q) begin
						if (pd_q[cur_q]) begin
							pd_q[cur_q] <= 1'b0;
							res_q.dead_valid <= 1'b1; res_q.dead_thread <= 6'(cur_q);
						end else if (ps_q[cur_q]) begin
							ps_q[cur_q] <= 1'b0;
							if (tc == CMAX) res_q.status_code <= SC_OVERFLOW;
						end else if (py_q[cur_q]) begin
							py_q[cur_q] <= 1'b0;
							if (qe_q) begin head_q <= cur_q; qe_q <= 1'b0; end
							tail_q <= cur_q;
						end else begin
							res_q.next_thread <= 6'(cur_q);
							do_rm_q <= 1'b1;
						end
					end
				BK_SEXEC:
					if (!do_rm_q) begin
						if (!qe_q) begin
							res_q.switched <= cur_idle_q || (head_q != cur_q);
							run_q <= head_q; idle_q <= 1'b0;
							res_q.next_thread <= 6'(head_q);
							if (head_q == tail_q) qe_q <= 1'b1;
							else head_q <= nx_q;
						end else begin
							res_q.switched <= !cur_idle_q;
							run_q <= '0; idle_q <= 1'b1;
							res_q.next_is_idle <= 1'b1;
						end
					end
				default: ;
			endcase
		end
	end

	// Link writes: append in EXEC or SCHED, splice out of the middle in LINK.
	logic app_exec, app_sched;
	assign app_exec = (st_q == BK_EXEC) && !op_q.bad && !qe_q && tst == ST_STOPPED &&
		(op_q.cmd == CMD_RESUME || op_q.cmd == CMD_ABORT) && tc == SUSPEND_BITS'(1);
	assign app_sched = (st_q == BK_SCHED) && !cur_idle_q && !qe_q && !pd_q[cur_q] &&
		!ps_q[cur_q] && py_q[cur_q];

	always_comb begin
		nxt_we = 1'b0; prv_we = 1'b0;
		nxt_wa = tail_q; prv_wa = t;
		nxt_wd = t; prv_wd = tail_q;
		if (app_exec) begin
			nxt_we = 1'b1; prv_we = 1'b1;
		end else if (app_sched) begin
			nxt_we = 1'b1; prv_we = 1'b1;
			nxt_wd = cur_q; prv_wa = cur_q;
		end else if (st_q == BK_LINK && do_rm_q && !qe_q &&
				!(head_q == t && tail_q == t)) begin
			nxt_we = (head_q != t); nxt_wa = pv_q; nxt_wd = nx_q;
			prv_we = (tail_q != t); prv_wa = nx_q; prv_wd = pv_q;
		end
	end
endmodule

// ===== sv/thread_suspend_run_queue_scheduler.sv =====
// Top level: thread scheduler with suspend counts and a linked FIFO run queue.
`timescale 1ns / 1ps
// Commands pass through a two-beat queue into an execution sequencer that owns
// the thread table and queue links. Each command yields one result beat. Every
// command holds the sequencer through the take from the queue, three working
// states (table commands read the entry and links, execute, splice; schedule
// settles the marks of the running entry read at the take, reads the head link,
// picks) and an output state, and the sequencer takes no new command until the
// result beat of the last one is taken. The table and link memories each have a
// single registered read port. A per-thread valid bit makes untouched table
// entries read as removed with a zero count, so no clearing pass is needed.
module thread_suspend_run_queue_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [5:0] thread_id,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status_code,
	output logic [5:0] next_thread,
	output logic       next_is_idle,
	output logic       switched,
	output logic       kick_cpu,
	output logic       interrupt_running,
	output logic       dead_valid,
	output logic [5:0] dead_thread
);
	import tsrq_pkg::*;

	logic op_valid, op_take;
	op_t  op;
	res_t res;

	tsrq_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.command(command), .thread_id(thread_id),
		.op_valid(op_valid), .op_take(op_take), .op(op)
	);

	tsrq_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_take(op_take), .op(op),
		.res_valid(out_valid), .res_stall(out_stall), .res(res)
	);

	assign status_code       = res.status_code;
	assign next_thread       = res.next_thread;
	assign next_is_idle      = res.next_is_idle;
	assign switched          = res.switched;
	assign kick_cpu          = res.kick_cpu;
	assign interrupt_running = res.interrupt_running;
	assign dead_valid        = res.dead_valid;
	assign dead_thread       = res.dead_thread;
endmodule
